// File: rtl/kec_pkg.sv
`timescale 1ns / 1ps

package kec_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int PAYLOAD_BITS  = 64;
  localparam int MAX_RESULTS   = 16;

  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int ECNT_W  = $clog2(MAX_RESULTS + 1);

  localparam logic FUNC_POST = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [1:0] KIND_PASS  = 2'd0;
  localparam logic [1:0] KIND_LEAD  = 2'd1;
  localparam logic [1:0] KIND_TRAIL = 2'd2;
  localparam logic [1:0] KIND_FULL  = 2'd3;

  typedef struct packed {
    logic        func;
    logic [7:0]  event_type;
    logic [31:0] sub_key;
    logic [63:0] payload;
    logic [15:0] window_ticks;
  } kec_in_t;

  typedef struct packed {
    logic [7:0]  out_type;
    logic [31:0] out_sub_key;
    logic [63:0] out_payload;
    logic [1:0]  emit_kind;
    logic        last_of_run;
    logic [4:0]  open_windows;
  } kec_out_t;

  typedef struct packed {
    logic                    valid;
    logic [7:0]              etype;
    logic [31:0]             sub_key;
    logic [15:0]             rem;
    logic [15:0]             win;
    logic                    pend;
    logic [PAYLOAD_BITS-1:0] pay;
  } kec_entry_t;

  typedef struct packed {
    logic                    set_valid;
    logic                    clr_valid;
    logic                    key_we;
    logic                    rem_we;
    logic                    win_we;
    logic                    pend_we;
    logic                    pay_we;
    logic [7:0]              etype;
    logic [31:0]             sub_key;
    logic [15:0]             rem;
    logic [15:0]             win;
    logic                    pend;
    logic [PAYLOAD_BITS-1:0] pay;
  } kec_wr_t;

endpackage

// File: rtl/keyed_event_coalescer.sv
`timescale 1ns / 1ps

// Per-key event coalescer with a 16-entry window table walked by one index, one entry per
// cycle while the output is not stalled. A post with a zero window gives its pass-through
// result by way of ST_POST_OUT. Any other post runs a serial key search with one 40-bit
// compare per cycle, then one update step and one result step; a post that only refreshes a
// pending payload gives no result. A tick counts the table down and then walks the entries
// that expired with something pending, giving a trailing result for each while out_stall is
// low. Every result of a tick carries the open-window count after the whole countdown.
// in_stall stays high from acceptance until the item is done and its last result, if any,
// has been loaded into the output register; the next item is taken while that result waits.

module keyed_event_coalescer import kec_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  kec_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output kec_out_t out_data
);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_SEARCH   = 6'b000010,
    ST_APPLY    = 6'b000100,
    ST_POST_OUT = 6'b001000,
    ST_TICK     = 6'b010000,
    ST_EMIT     = 6'b100000
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  state_t                   state_r, state_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  kec_in_t                  item_r, item_nxt;
  logic                     hit_r, hit_nxt;
  logic [IDX_W-1:0]         hit_idx_r, hit_idx_nxt;
  logic                     free_r, free_nxt;
  logic [IDX_W-1:0]         free_idx_r, free_idx_nxt;
  logic [1:0]               kind_r, kind_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [ECNT_W-1:0]        ecnt_r, ecnt_nxt;
  logic [TABLE_ENTRIES-1:0] mask_r, mask_nxt;
  logic                     out_valid_r, out_valid_nxt;
  kec_out_t                 out_r, out_nxt;

  kec_entry_t entry;
  kec_wr_t    wr;
  logic       key_match;
  logic       is_last;
  logic       out_free;
  logic [PAYLOAD_BITS-1:0] item_pay;

  kec_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .idx   (idx_r),
    .wr    (wr),
    .rd    (entry)
  );

  assign key_match = (entry.etype == item_r.event_type) && (entry.sub_key == item_r.sub_key);
  assign is_last   = (idx_r == LAST_IDX);
  assign out_free  = !out_valid_r || !out_stall;
  assign item_pay  = item_r.payload[PAYLOAD_BITS-1:0];

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    item_nxt      = item_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    kind_nxt      = kind_r;
    count_nxt     = count_r;
    ecnt_nxt      = ecnt_r;
    mask_nxt      = mask_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    wr            = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          idx_nxt  = '0;
          if (in_data.func == FUNC_TICK) begin
            ecnt_nxt  = '0;
            mask_nxt  = '0;
            state_nxt = ST_TICK;
          end else if (in_data.window_ticks == 16'd0) begin
            kind_nxt  = KIND_PASS;
            state_nxt = ST_POST_OUT;
          end else begin
            hit_nxt   = 1'b0;
            free_nxt  = 1'b0;
            state_nxt = ST_SEARCH;
          end
        end
      end

      ST_SEARCH: begin
        if (entry.valid) begin
          if (!hit_r && key_match) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = idx_r;
          end
        end else if (!free_r) begin
          free_nxt     = 1'b1;
          free_idx_nxt = idx_r;
        end
        if (is_last) begin
          idx_nxt   = hit_nxt ? hit_idx_nxt : free_idx_nxt;
          state_nxt = ST_APPLY;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      ST_APPLY: begin
        if (hit_r) begin
          wr.pend_we = 1'b1;
          wr.pend    = 1'b1;
          wr.pay_we  = 1'b1;
          wr.pay     = item_pay;
          wr.win_we  = 1'b1;
          wr.win     = item_r.window_ticks;
          state_nxt  = ST_IDLE;
        end else if (free_r) begin
          wr.set_valid = 1'b1;
          wr.key_we    = 1'b1;
          wr.etype     = item_r.event_type;
          wr.sub_key   = item_r.sub_key;
          wr.rem_we    = 1'b1;
          wr.rem       = item_r.window_ticks;
          wr.win_we    = 1'b1;
          wr.win       = item_r.window_ticks;
          wr.pend_we   = 1'b1;
          wr.pend      = 1'b0;
          count_nxt    = count_r + 1'b1;
          kind_nxt     = KIND_LEAD;
          state_nxt    = ST_POST_OUT;
        end else begin
          kind_nxt  = KIND_FULL;
          state_nxt = ST_POST_OUT;
        end
      end

      ST_POST_OUT: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt.out_type     = item_r.event_type;
          out_nxt.out_sub_key  = item_r.sub_key;
          out_nxt.out_payload  = 64'(item_pay);
          out_nxt.emit_kind    = kind_r;
          out_nxt.last_of_run  = 1'b1;
          out_nxt.open_windows = 5'(count_r);
          state_nxt            = ST_IDLE;
        end
      end

      ST_TICK: begin
        if (entry.valid) begin
          if (entry.rem > 16'd1) begin
            wr.rem_we = 1'b1;
            wr.rem    = entry.rem - 16'd1;
          end else if (entry.pend) begin
            wr.rem_we = 1'b1;
            if (ecnt_r == ECNT_W'(MAX_RESULTS)) begin
              wr.rem = 16'd1;
            end else begin
              mask_nxt[idx_r] = 1'b1;
              wr.pend_we      = 1'b1;
              wr.pend         = 1'b0;
              wr.rem          = (entry.win != 16'd0) ? entry.win : 16'd1;
              ecnt_nxt        = ecnt_r + 1'b1;
            end
          end else begin
            wr.clr_valid = 1'b1;
            count_nxt    = count_r - 1'b1;
          end
        end
        if (is_last) begin
          idx_nxt   = '0;
          state_nxt = (mask_nxt != '0) ? ST_EMIT : ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      ST_EMIT: begin
        if (mask_r[idx_r]) begin
          if (out_free) begin
            mask_nxt[idx_r]      = 1'b0;
            out_valid_nxt        = 1'b1;
            out_nxt.out_type     = entry.etype;
            out_nxt.out_sub_key  = entry.sub_key;
            out_nxt.out_payload  = 64'(entry.pay);
            out_nxt.emit_kind    = KIND_TRAIL;
            out_nxt.last_of_run  = (mask_nxt == '0);
            out_nxt.open_windows = 5'(count_r);
            if (mask_nxt == '0) begin
              state_nxt = ST_IDLE;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    item_r     <= item_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_r     <= free_nxt;
    free_idx_r <= free_idx_nxt;
    kind_r     <= kind_nxt;
    ecnt_r     <= ecnt_nxt;
    mask_r     <= mask_nxt;
    out_r      <= out_nxt;
  end

  assign in_stall  = !rst_n || (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/kec_table.sv
`timescale 1ns / 1ps

module kec_table import kec_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] idx,
  input  kec_wr_t          wr,
  output kec_entry_t       rd
);

  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [7:0]               type_r    [TABLE_ENTRIES];
  logic [31:0]              sub_r     [TABLE_ENTRIES];
  logic [15:0]              rem_r     [TABLE_ENTRIES];
  logic [15:0]              win_r     [TABLE_ENTRIES];
  logic                     pend_r    [TABLE_ENTRIES];
  logic [PAYLOAD_BITS-1:0]  pay_r     [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.set_valid) begin
      valid_r[idx] <= 1'b1;
    end else if (wr.clr_valid) begin
      valid_r[idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.key_we) begin
      type_r[idx] <= wr.etype;
      sub_r[idx]  <= wr.sub_key;
    end
    if (wr.rem_we) begin
      rem_r[idx] <= wr.rem;
    end
    if (wr.win_we) begin
      win_r[idx] <= wr.win;
    end
    if (wr.pend_we) begin
      pend_r[idx] <= wr.pend;
    end
    if (wr.pay_we) begin
      pay_r[idx] <= wr.pay;
    end
  end

  always_comb begin
    rd.valid   = valid_r[idx];
    rd.etype   = type_r[idx];
    rd.sub_key = sub_r[idx];
    rd.rem     = rem_r[idx];
    rd.win     = win_r[idx];
    rd.pend    = pend_r[idx];
    rd.pay     = pay_r[idx];
  end

endmodule

// File: rtl/kec_checker.sv
`timescale 1ns / 1ps

module kec_checker import kec_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input kec_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input kec_out_t out_data
);

  // a result waiting at the output holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // every accepted item leaves the block busy in the cycle after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted without busy cycle");

  // only trailing results come in runs
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.emit_kind != KIND_TRAIL) |-> out_data.last_of_run)
    else $error("single result not marked last");

  // a leading edge has just opened a window
  a_lead_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.emit_kind == KIND_LEAD) |-> (out_data.open_windows != 5'd0))
    else $error("leading edge with no open window");

  // a pass-through item accepted while the output is not held goes through ST_POST_OUT into the output register
  a_pass_delay: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.func == FUNC_POST) && (in_data.window_ticks == 16'd0)
    && !(out_valid && out_stall) |=> ##1 out_valid && (out_data.emit_kind == KIND_PASS))
    else $error("pass-through item missing");

endmodule

bind keyed_event_coalescer kec_checker u_kec_checker (.*);
